// ===== rtl/core/keypad_number_entry_display_core_assert.svh =====
// assertion macros for the keypad entry core
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef KEYPAD_NUMBER_ENTRY_DISPLAY_CORE_ASSERT_SVH
`define KEYPAD_NUMBER_ENTRY_DISPLAY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define KNED_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kned assertion failed");
`define KNED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error("kned sequence assertion failed");
`else
`define KNED_ASSERT(lbl, clk, rst, prop)
`define KNED_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/kned_pkg.sv =====
// types, constants and lookup functions of the keypad entry core
// no dependencies; used by kned_bin2bcd and keypad_number_entry_display_core
`default_nettype none

package kned_pkg;

   localparam int unsigned KeyCount    = 16;
   localparam int unsigned KeyIdxWidth = $clog2(KeyCount);
   localparam int unsigned ValueWidth  = 14;
   localparam int unsigned DigitCount  = 4;
   localparam int unsigned BcdWidth    = 4 * DigitCount;

   localparam logic [KeyIdxWidth-1:0] StarKey       = 4'd3;
   localparam logic [KeyIdxWidth-1:0] LastKey       = 4'd15;
   localparam logic [ValueWidth-1:0]  ValueLimit    = 14'd1000;
   localparam logic [ValueWidth-1:0]  ValueMax      = 14'd9999;
   localparam logic [3:0]             ConvLastStep  = 4'd13;
   localparam logic [1:0]             LastPosition  = 2'd3;
   localparam logic [7:0]             BlankSegments = 8'hFF;

   typedef logic [DigitCount-1:0][3:0] digit_vec_type;

   typedef struct packed {
      logic          done;
      digit_vec_type digits;   // element 3 is the most significant digit
   } conv_result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] digit;
   } key_digit_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_KEYS  = 5'b00010,
      ST_START = 5'b00100,
      ST_CONV  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // key code k = column*4+row
   function automatic key_digit_type key_digit(input logic [KeyIdxWidth-1:0] key);
      key_digit_type kd;
      kd.valid = 1'b1;
      case (key)
         4'd0:    kd.digit = 4'd1;
         4'd1:    kd.digit = 4'd4;
         4'd2:    kd.digit = 4'd7;
         4'd4:    kd.digit = 4'd2;
         4'd5:    kd.digit = 4'd5;
         4'd6:    kd.digit = 4'd8;
         4'd7:    kd.digit = 4'd0;
         4'd8:    kd.digit = 4'd3;
         4'd9:    kd.digit = 4'd6;
         4'd10:   kd.digit = 4'd9;
         default: begin
            kd.valid = 1'b0;
            kd.digit = 4'd0;
         end
      endcase
      return kd;
   endfunction

   // active-low a..g, point off
   function automatic logic [7:0] digit_segments_n(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = BlankSegments;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kned_bin2bcd.sv =====
// iterative binary to bcd converter, shift-and-add-3, one bit per cycle
// depends on kned_pkg
`default_nettype none

module kned_bin2bcd (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [kned_pkg::ValueWidth-1:0] value_bin,
   output      kned_pkg::conv_result_type      result
);

   logic                            busy_ff,  busy_in;
   logic                            done_ff,  done_in;
   logic [3:0]                      count_ff, count_in;
   logic [kned_pkg::ValueWidth-1:0] bin_ff,   bin_in;
   logic [kned_pkg::BcdWidth-1:0]   bcd_ff,   bcd_in;
   logic [kned_pkg::BcdWidth-1:0]   bcd_adj;

   // add 3 to every nibble of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < kned_pkg::DigitCount; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5)
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         else
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 4'd0;
         bin_in   = value_bin;
         bcd_in   = '0;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {bcd_adj[kned_pkg::BcdWidth-2:0], bin_ff, 1'b0};
         count_in = count_ff + 4'd1;
         if (count_ff == kned_pkg::ConvLastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
   end

   assign result.done   = done_ff;
   assign result.digits = bcd_ff;

endmodule

`default_nettype wire

// ===== rtl/core/keypad_number_entry_display_core.sv =====
// Each accepted scan gives four digit transfers, one per position; the next scan is accepted
// only after the last digit has been taken, and rsp_ready low holds a digit.
// Between a scan and its first digit lie the walk over the key codes (one key a cycle through
// the shared multiply-add) and the fourteen-step binary-to-bcd converter.
// Reset (synchronous, active high): all keys released, value 0, leading zeros blanked.
`default_nettype none
`include "keypad_number_entry_display_core_assert.svh"

module keypad_number_entry_display_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [15:0] req_key_levels_n,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_digit_position,
   output      logic [7:0]  rsp_segments_n,
   output      logic [13:0] rsp_entry_value,
   output      logic        rsp_last_digit,
   input  wire logic        csr_write_en,
   input  wire logic        csr_show_leading_zeros
);

   kned_pkg::state_type                state_ff, state_in;
   logic [kned_pkg::KeyCount-1:0]      prev_ff, prev_in;
   logic [kned_pkg::KeyCount-1:0]      pressed_ff, pressed_in;
   logic [kned_pkg::KeyIdxWidth-1:0]   key_idx_ff, key_idx_in;
   logic [kned_pkg::ValueWidth-1:0]    value_ff, value_in;
   logic                               show_lz_ff;
   logic [1:0]                         pos_ff, pos_in;
   logic [7:0]                         seg_ff, seg_in;
   logic                               lead_ff, lead_in;

   kned_pkg::key_digit_type            kd;
   kned_pkg::conv_result_type          conv;
   logic                               conv_start;
   logic                               req_xfer, rsp_xfer;
   logic [1:0]                         sel_pos;
   logic                               sel_lead, sel_zero, sel_blank;
   logic [3:0]                         sel_digit;

   assign req_xfer   = req_valid && req_ready;
   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign conv_start = (state_ff == kned_pkg::ST_START);
   assign kd         = kned_pkg::key_digit(key_idx_ff);

   kned_bin2bcd u_bin2bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .value_bin (value_ff),
      .result    (conv)
   );

   // digit shown at the position being loaded into the output register
   always_comb begin
      if (state_ff == kned_pkg::ST_CONV) begin
         sel_pos  = 2'd0;
         sel_lead = !show_lz_ff;
      end else begin
         sel_pos  = pos_ff + 2'd1;
         sel_lead = lead_ff;
      end
      sel_digit = conv.digits[2'd3 - sel_pos];
      sel_zero  = (sel_digit == 4'd0);
      sel_blank = sel_lead && sel_zero && (sel_pos != kned_pkg::LastPosition);
   end

   always_comb begin
      state_in   = state_ff;
      prev_in    = prev_ff;
      pressed_in = pressed_ff;
      key_idx_in = key_idx_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      seg_in     = seg_ff;
      lead_in    = lead_ff;
      case (state_ff)
         kned_pkg::ST_IDLE: begin
            if (req_xfer) begin
               pressed_in = ~req_key_levels_n & prev_ff;
               prev_in    = req_key_levels_n;
               key_idx_in = '0;
               state_in   = kned_pkg::ST_KEYS;
            end
         end
         kned_pkg::ST_KEYS: begin
            if (pressed_ff[key_idx_ff]) begin
               if (kd.valid) begin
                  if (value_ff < kned_pkg::ValueLimit)
                     value_in = value_ff * 14'd10 + {10'd0, kd.digit};
               end else if (key_idx_ff == kned_pkg::StarKey) begin
                  value_in = '0;
               end
            end
            key_idx_in = key_idx_ff + 4'd1;
            if (key_idx_ff == kned_pkg::LastKey)
               state_in = kned_pkg::ST_START;
         end
         kned_pkg::ST_START: begin
            state_in = kned_pkg::ST_CONV;
         end
         kned_pkg::ST_CONV: begin
            if (conv.done) begin
               pos_in   = sel_pos;
               seg_in   = sel_blank ? kned_pkg::BlankSegments
                                    : kned_pkg::digit_segments_n(sel_digit);
               lead_in  = sel_lead && sel_zero;
               state_in = kned_pkg::ST_EMIT;
            end
         end
         kned_pkg::ST_EMIT: begin
            if (rsp_xfer) begin
               if (pos_ff == kned_pkg::LastPosition) begin
                  state_in = kned_pkg::ST_IDLE;
               end else begin
                  pos_in  = sel_pos;
                  seg_in  = sel_blank ? kned_pkg::BlankSegments
                                      : kned_pkg::digit_segments_n(sel_digit);
                  lead_in = sel_lead && sel_zero;
               end
            end
         end
         default: begin
            state_in = kned_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= kned_pkg::ST_IDLE;
         prev_ff    <= '1;
         value_ff   <= '0;
         show_lz_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         value_ff <= value_in;
         if (csr_write_en)
            show_lz_ff <= csr_show_leading_zeros;
      end
      pressed_ff <= pressed_in;
      key_idx_ff <= key_idx_in;
      pos_ff     <= pos_in;
      seg_ff     <= seg_in;
      lead_ff    <= lead_in;
   end

   assign req_ready          = (state_ff == kned_pkg::ST_IDLE);
   assign rsp_valid          = (state_ff == kned_pkg::ST_EMIT);
   assign rsp_digit_position = pos_ff;
   assign rsp_segments_n     = seg_ff;
   assign rsp_entry_value    = value_ff;
   assign rsp_last_digit     = (pos_ff == kned_pkg::LastPosition);

   `KNED_ASSERT(a_no_overlap, clock, reset, !(req_ready && rsp_valid))
   `KNED_ASSERT(a_value_range, clock, reset, value_ff <= kned_pkg::ValueMax)
   `KNED_ASSERT_NEXT(a_accept_starts_walk, clock, reset, req_xfer, (state_ff == kned_pkg::ST_KEYS) && (key_idx_ff == 4'd0))
   `KNED_ASSERT_NEXT(a_last_ends_scan, clock, reset, rsp_xfer && rsp_last_digit, req_ready && !rsp_valid)
   `KNED_ASSERT_NEXT(a_value_held_in_emit, clock, reset, rsp_valid && !rsp_last_digit, $stable(rsp_entry_value))

endmodule

`default_nettype wire

// ===== bench/tb_keypad_number_entry_display_core.sv =====
// testbench for keypad_number_entry_display_core: keypad scans in, four digit transfers out
// depends on kned_pkg and the core; a scoreboard class predicts entered value and segments
`timescale 1ns / 100ps

module tb_keypad_number_entry_display_core;

   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned DrainCycles   = 40;
   localparam logic [3:0]  NoDigit       = 4'hF;
   localparam logic [15:0] AllReleased   = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  position;
      logic [7:0]  segments_n;
      logic [13:0] value;
      logic        last;
   } display_digit_type;

   class entry_scoreboard;
      logic [15:0]       prev_levels;
      logic [13:0]       entry;
      bit                show_zeros;
      int                errors;
      display_digit_type expected_digits[$];
      logic [3:0]        key_to_digit[16];
      logic [7:0]        shape_n[10];

      function new();
         key_to_digit = '{4'd1, 4'd4, 4'd7, NoDigit, 4'd2, 4'd5, 4'd8, 4'd0,
                          4'd3, 4'd6, 4'd9, NoDigit, NoDigit, NoDigit, NoDigit, NoDigit};
         shape_n = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                     8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
         prev_levels = AllReleased;
         entry = '0;
         show_zeros = 1'b0;
         errors = 0;
      endfunction

      // new presses in ascending key order, then the four display digits
      function void note_scan(logic [15:0] levels);
         logic [15:0]       pressed;
         logic [3:0]        dec[4];
         bit                leading;
         display_digit_type d;
         pressed = ~levels & prev_levels;
         for (int k = 0; k < 16; k++) begin
            if (pressed[k]) begin
               if (key_to_digit[k] != NoDigit) begin
                  if (entry < kned_pkg::ValueLimit)
                     entry = 14'(entry * 10 + key_to_digit[k]);
               end else if (4'(k) == kned_pkg::StarKey) begin
                  entry = '0;
               end
            end
         end
         prev_levels = levels;
         dec[3] = 4'(entry % 10);
         dec[2] = 4'((entry / 10) % 10);
         dec[1] = 4'((entry / 100) % 10);
         dec[0] = 4'((entry / 1000) % 10);
         leading = !show_zeros;
         for (int k = 0; k < 4; k++) begin
            d.position = 2'(k);
            d.segments_n = shape_n[dec[k]];
            // units digit is never blanked
            if (k < 3 && leading) begin
               if (dec[k] == 4'd0)
                  d.segments_n = kned_pkg::BlankSegments;
               else
                  leading = 1'b0;
            end
            d.value = entry;
            d.last = (2'(k) == kned_pkg::LastPosition);
            expected_digits.push_back(d);
         end
      endfunction

      function void check_digit(display_digit_type got);
         display_digit_type want;
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected digit transfer position %0d segments %h value %0d",
                     $time, got.position, got.segments_n, got.value);
            errors++;
            return;
         end
         want = expected_digits.pop_front();
         if (got.position !== want.position) begin
            $display("%0t: position expected %0d got %0d", $time, want.position, got.position);
            errors++;
         end
         if (got.segments_n !== want.segments_n) begin
            $display("%0t: segments_n expected %h got %h", $time, want.segments_n,
                     got.segments_n);
            errors++;
         end
         if (got.value !== want.value) begin
            $display("%0t: entry_value expected %0d got %0d", $time, want.value, got.value);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_digit expected %b got %b", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_key_levels_n = AllReleased;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_digit_position;
   logic [7:0]  rsp_segments_n;
   logic [13:0] rsp_entry_value;
   logic        rsp_last_digit;
   logic        csr_write_en = 1'b0;
   logic        csr_show_leading_zeros = 1'b0;

   entry_scoreboard sb = new();
   logic [15:0]     last_levels = AllReleased;
   logic [15:0]     ready_pattern = 16'hFFFF;
   int              pattern_left = 0;
   int unsigned     idle_cycles = 0;

   keypad_number_entry_display_core uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_key_levels_n       (req_key_levels_n),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_digit_position     (rsp_digit_position),
      .rsp_segments_n         (rsp_segments_n),
      .rsp_entry_value        (rsp_entry_value),
      .rsp_last_digit         (rsp_last_digit),
      .csr_write_en           (csr_write_en),
      .csr_show_leading_zeros (csr_show_leading_zeros)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // receiver stalls follow a rotating mask that is redrawn now and then
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         if ($urandom_range(0, 2) == 0)
            ready_pattern <= 16'hFFFF;
         else
            ready_pattern <= 16'($urandom) | 16'h0001;
         pattern_left <= $urandom_range(40, 300);
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
         pattern_left <= pattern_left - 1;
      end
      rsp_ready <= ready_pattern[0];
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_digit({rsp_digit_position, rsp_segments_n, rsp_entry_value, rsp_last_digit});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WatchdogLimit) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_scan(input logic [15:0] levels);
      req_valid <= 1'b1;
      req_key_levels_n <= levels;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_scan(levels);
      last_levels = levels;
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold off until the display has caught up with every scan sent
   task automatic drain_display();
      req_valid <= 1'b0;
      while (sb.expected_digits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_show_zeros(input bit setting);
      csr_write_en <= 1'b1;
      csr_show_leading_zeros <= setting;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.show_zeros = setting;
   endtask

   // mostly single key presses, some releases, drift and raw noise
   function automatic logic [15:0] pick_levels();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return 16'($urandom);
      else if (roll < 20)
         return last_levels ^ (16'h0001 << $urandom_range(0, 15));
      else if (roll < 32)
         return AllReleased;
      else if (roll < 38)
         return ~(16'h0001 << kned_pkg::StarKey);
      else if (roll < 45)
         return ~((16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15)));
      else
         return ~(16'h0001 << $urandom_range(0, 10));
   endfunction

   task automatic run_random_scans(input int count);
      int burst_left;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
            burst_left = $urandom_range(1, 12);
         end
         send_scan(pick_levels());
         burst_left--;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_show_zeros(1'b0);

      // directed: presses, held key, cap at 1000, star, several presses in one scan
      send_scan(AllReleased);
      send_scan(~16'h0001);
      send_scan(~16'h0001);
      send_scan(AllReleased);
      send_scan(~16'h0010);
      send_scan(~16'h0100);
      send_scan(~16'h0002);
      send_scan(~16'h0400);
      send_scan(~(16'h0001 << kned_pkg::StarKey));
      send_scan(16'h0000);
      send_scan(AllReleased);
      send_scan(16'h0000);
      send_scan(AllReleased);
      send_scan(~16'h0080);
      send_scan(~16'h0040);
      send_scan(16'h07FF);
      send_scan(~16'h0024);
      send_scan(~16'h0200);
      send_scan(~(16'h0001 << kned_pkg::StarKey));
      send_scan(~16'h0001);
      send_scan(~16'h0080);
      send_scan(AllReleased);
      send_scan(~16'h0080);
      send_scan(AllReleased);
      send_scan(~16'h0080);
      send_scan(~16'h0001);

      drain_display();
      write_show_zeros(1'b1);
      run_random_scans(150);
      drain_display();
      write_show_zeros(1'b0);
      run_random_scans(145);
      drain_display();
      write_show_zeros(1'b1);
      run_random_scans(145);

      drain_display();
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/kned_pkg.sv
rtl/core/kned_bin2bcd.sv
rtl/core/keypad_number_entry_display_core.sv
bench/tb_keypad_number_entry_display_core.sv
